[src/cbd_pkg.sv]
`default_nettype none
package cbd_pkg;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;

  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_CR,
    CLS_LF,
    CLS_SEMI,
    CLS_WS,
    CLS_HEX,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    logic [7:0] raw;
    cls_t       cls;
    logic [3:0] hexv;
  } entry_t;

  typedef enum logic [5:0] {
    PH_SIZE    = 6'b000001,
    PH_DATA    = 6'b000010,
    PH_DATA_CR = 6'b000100,
    PH_DATA_LF = 6'b001000,
    PH_TRAILER = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY      = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_BAD       = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef struct packed {
    logic digit;
    logic after;
    logic ext;
    logic cr;
    logic ovf;
  } flags_t;

endpackage
`default_nettype wire

[src/cbd_front.sv]
`default_nettype none
module cbd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      data_byte,
  input  wire logic            data_valid,
  output logic                 data_ready,
  output cbd_pkg::entry_t      q_entry,
  output logic                 q_valid,
  input  wire logic            q_ready
);
  import cbd_pkg::*;

  function automatic entry_t classify(input logic [7:0] b);
    entry_t e;
    e.raw  = b;
    e.hexv = '0;
    e.cls  = CLS_OTHER;
    if (b == CH_CR) begin
      e.cls = CLS_CR;
    end else if (b == CH_LF) begin
      e.cls = CLS_LF;
    end else if (b == CH_SEMI) begin
      e.cls = CLS_SEMI;
    end else if (b == CH_SP || b == CH_TAB) begin
      e.cls = CLS_WS;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      e.cls  = CLS_HEX;
      e.hexv = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      e.cls  = CLS_HEX;
      e.hexv = 4'(b[3:0] + 4'd9);
    end
    return e;
  endfunction

  logic   fv;
  entry_t fentry;

  assign data_ready = !fv || q_ready;
  assign q_valid    = fv;
  assign q_entry    = fentry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (data_ready) begin
      fv <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      fentry <= classify(data_byte);
    end
  end

endmodule
`default_nettype wire

[src/cbd_queue.sv]
`default_nettype none
module cbd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cbd_pkg::entry_t wr_entry,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  output cbd_pkg::entry_t      rd_entry,
  output logic                 rd_valid,
  input  wire logic            rd_ready
);
  import cbd_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_entry = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

[src/cbd_exec.sv]
`default_nettype none
module cbd_exec #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wen,
  input  wire logic [31:0]     cfg_wdata,
  input  wire cbd_pkg::entry_t rd_entry,
  input  wire logic            rd_valid,
  output logic                 rd_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           body_byte,
  output logic                 body_valid,
  output logic [1:0]           status
);
  import cbd_pkg::*;

  localparam int CW = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 1;

  logic [31:0]          max_body_size;
  phase_t               phase, phase_next;
  status_t              final_status, final_status_next;
  logic [31:0]          chunk_remaining, chunk_remaining_next;
  logic [31:0]          body_total, body_total_next;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  flags_t               flags, flags_next;
  logic [7:0]           ob;
  logic                 ov;
  logic                 pop;
  logic [CW-1:0]        sum;
  logic                 too_big;

  assign rd_ready = !out_valid || out_ready;
  assign pop      = rd_valid && rd_ready;
  assign sum      = CW'(body_total) + CW'(size_accum);
  assign too_big  = sum > CW'(max_body_size);

  always_comb begin
    flags_t fl;
    phase_next           = phase;
    final_status_next    = final_status;
    chunk_remaining_next = chunk_remaining;
    body_total_next      = body_total;
    size_accum_next      = size_accum;
    flags_next           = flags;
    ob                   = '0;
    ov                   = 1'b0;
    fl                   = flags;
    unique case (phase)
      PH_SIZE: begin
        if (flags.cr && rd_entry.cls == CLS_LF) begin
          size_accum_next = '0;
          flags_next      = '0;
          if (!flags.digit) begin
            phase_next        = PH_DONE;
            final_status_next = ST_BAD;
          end else if (flags.ovf) begin
            phase_next        = PH_DONE;
            final_status_next = ST_TOO_LARGE;
          end else if (size_accum == '0) begin
            phase_next = PH_TRAILER;
          end else if (too_big) begin
            phase_next        = PH_DONE;
            final_status_next = ST_TOO_LARGE;
          end else begin
            chunk_remaining_next = 32'(size_accum);
            phase_next           = PH_DATA;
          end
        end else if (flags.cr && !flags.ext) begin
          flags_next.cr     = 1'b0;
          phase_next        = PH_DONE;
          final_status_next = ST_BAD;
        end else begin
          fl.cr = 1'b0;
          if (rd_entry.cls == CLS_CR) begin
            fl.cr = 1'b1;
          end else if (fl.ext) begin
            fl.ext = 1'b1;
          end else if (rd_entry.cls == CLS_SEMI) begin
            if (!fl.digit) begin
              phase_next        = PH_DONE;
              final_status_next = ST_BAD;
            end else begin
              fl.ext = 1'b1;
            end
          end else if (rd_entry.cls == CLS_WS) begin
            if (fl.digit) begin
              fl.after = 1'b1;
            end
          end else if (rd_entry.cls == CLS_HEX && !fl.after) begin
            fl.digit = 1'b1;
            if (!fl.ovf) begin
              if (size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                fl.ovf = 1'b1;
              end else begin
                size_accum_next = {size_accum[SIZE_BITS-5:0], rd_entry.hexv};
              end
            end
          end else begin
            phase_next        = PH_DONE;
            final_status_next = ST_BAD;
          end
          flags_next = fl;
        end
      end
      PH_DATA: begin
        ob              = rd_entry.raw;
        ov              = 1'b1;
        body_total_next = body_total + 32'd1;
        if (chunk_remaining != '0) begin
          chunk_remaining_next = chunk_remaining - 32'd1;
        end
        if (chunk_remaining <= 32'd1) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (rd_entry.cls == CLS_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          phase_next        = PH_DONE;
          final_status_next = ST_BAD;
        end
      end
      PH_DATA_LF: begin
        if (rd_entry.cls == CLS_LF) begin
          phase_next      = PH_SIZE;
          flags_next      = '0;
          size_accum_next = '0;
        end else begin
          phase_next        = PH_DONE;
          final_status_next = ST_BAD;
        end
      end
      PH_TRAILER: begin
        if (flags.cr && rd_entry.cls == CLS_LF) begin
          if (!flags.digit) begin
            phase_next        = PH_DONE;
            final_status_next = ST_COMPLETE;
          end
          flags_next = '0;
        end else begin
          if (fl.cr) begin
            fl.cr    = 1'b0;
            fl.digit = 1'b1;
          end
          if (rd_entry.cls == CLS_CR) begin
            fl.cr = 1'b1;
          end else begin
            fl.digit = 1'b1;
          end
          flags_next = fl;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_size <= MAX_BODY_RESET;
    end else if (cfg_wen) begin
      max_body_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      final_status    <= ST_BUSY;
      chunk_remaining <= '0;
      body_total      <= '0;
      size_accum      <= '0;
      flags           <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        phase           <= phase_next;
        final_status    <= final_status_next;
        chunk_remaining <= chunk_remaining_next;
        body_total      <= body_total_next;
        size_accum      <= size_accum_next;
        flags           <= flags_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      body_byte  <= ob;
      body_valid <= ov;
      status     <= final_status_next;
    end
  end

  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    final_status != ST_BUSY |=> final_status == $past(final_status))
    else $error("final status changed after being set");

  a_done_matches_status: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) == (final_status != ST_BUSY))
    else $error("done phase and final status disagree");

  a_data_has_remaining: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> chunk_remaining != '0)
    else $error("data phase with no bytes remaining");

  a_body_only_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && body_valid |-> status == ST_BUSY)
    else $error("body byte passed out with final status");

endmodule
`default_nettype wire

[src/chunked_body_decoder_unit.sv]
`default_nettype none
// Chunked transfer body decoder: takes the raw body of a chunked message one
// byte per transaction on data_byte and returns exactly one result transaction
// per input byte, carrying the decoded payload byte (body_valid high for chunk
// data), and the running status: in progress, complete, bad request or too
// large. Sustained rate is one byte per clock with out_ready high; the
// per-byte state update in the execute stage sets that figure. A byte's
// result passes the classify register, queue slot and output register; the
// two sides stall independently through that queue. max_body_size is checked
// against the running body total plus the chunk size when each size line ends
// and must only be written while the decoder is idle. Once complete or in
// error the status sticks and later bytes return body_valid low until reset.
module chunked_body_decoder_unit #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic [7:0]  data_byte,
  input  wire logic        data_valid,
  output logic             data_ready,
  output logic [7:0]       body_byte,
  output logic             body_valid,
  output logic [1:0]       status,
  output logic             out_valid,
  input  wire logic        out_ready
);
  import cbd_pkg::*;

  entry_t f_entry;
  logic   f_valid;
  logic   f_ready;
  entry_t q_entry;
  logic   q_valid;
  logic   q_ready;

  cbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .q_entry    (f_entry),
    .q_valid    (f_valid),
    .q_ready    (f_ready)
  );

  cbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_entry (f_entry),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_entry (q_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  cbd_exec #(
    .SIZE_BITS (SIZE_BITS)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .rd_entry   (q_entry),
    .rd_valid   (q_valid),
    .rd_ready   (q_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .body_byte  (body_byte),
    .body_valid (body_valid),
    .status     (status)
  );

endmodule
`default_nettype wire
